// ----- src/grp7_pkg.sv -----
// Shared constants and the byte rebuild function of the group-of-seven packet decoder.
package grp7_pkg;

  localparam int unsigned PosW = 11;
  localparam int unsigned CountW = 10;

  localparam logic [PosW-1:0] HdrLen = 11'd7;
  localparam logic [PosW-1:0] OddCountPos = 11'd5;
  localparam logic [PosW-1:0] GroupCountPos = 11'd6;

  localparam logic [7:0] Low7Mask = 8'h7f;
  localparam logic [7:0] ChkMask = 8'h55;
  localparam logic [7:0] TopBit = 8'h80;

  localparam logic [CountW-1:0] DataCountMax = 10'd1016;

  // Slots one to seven take bit (7 - slot) of the carrier byte as bit 7; other slots give 0.
  function automatic logic [7:0] rebuild(input logic [7:0] msb, input logic [PosW-1:0] slot,
                                         input logic [7:0] low);
    logic hi;
    hi = 1'b0;
    if (slot >= 11'd1 && slot <= 11'd7) begin
      hi = msb[3'd7 - slot[2:0]];
    end
    return ({hi, 7'd0} & TopBit) | (low & Low7Mask);
  endfunction

endpackage

// ----- src/group7_packet_decoder.sv -----
// Top level of the group-of-seven data packet decoder.
// One received byte is accepted per clock cycle; each byte is decoded in the cycle it is
// accepted and gives zero or one result, which an output register holds in the next cycle.
// Input ready stays high while that register is empty or is being read, so a steady stream
// runs at one byte per cycle and only a stalled result request holds the input back.
// Header and MSB carrier bytes give no result; data bytes give a data result and the second
// checksum byte gives the final result with the mismatch flag and the byte count.
module group7_packet_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  rx_byte_i,
  input  logic                        start_of_packet_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  data_byte_o,
  output logic                        is_final_o,
  output logic                        checksum_error_o,
  output logic [grp7_pkg::CountW-1:0] data_count_o
);
  import grp7_pkg::*;

  logic            active_q, active_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [6:0]      odd_total_q, odd_total_d;
  logic [6:0]      group_total_q, group_total_d;
  logic [7:0]      odd_msb_q, odd_msb_d;
  logic [7:0]      group_msb_q, group_msb_d;
  logic [7:0]      csum_q, csum_d;
  logic [7:0]      even_bits_q, even_bits_d;

  logic              out_valid_q;
  logic [7:0]        data_byte_q;
  logic              is_final_q;
  logic              chk_err_q;
  logic [CountW-1:0] count_q;

  logic              accept;
  logic              res_valid;
  logic [7:0]        res_data;
  logic              res_final;
  logic              res_err;
  logic [CountW-1:0] res_count;

  logic              cur_active;
  logic [PosW-1:0]   cur_pos;
  logic [6:0]        cur_odd;
  logic [6:0]        cur_group;
  logic [7:0]        cur_odd_msb;
  logic [7:0]        cur_group_msb;
  logic [7:0]        cur_csum;
  logic [7:0]        cur_even;

  logic [PosW-1:0]   rel;
  logic [PosW-1:0]   rel_grp;
  logic [PosW-1:0]   rel_chk;
  logic [PosW-1:0]   odd_len;
  logic [PosW-1:0]   grp_len;
  logic [7:0]        expect_sum;
  logic [7:0]        dec;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    // A start byte begins from cleared state, whatever was in progress.
    if (start_of_packet_i) begin
      cur_active    = 1'b1;
      cur_pos       = '0;
      cur_odd       = '0;
      cur_group     = '0;
      cur_odd_msb   = '0;
      cur_group_msb = '0;
      cur_csum      = '0;
      cur_even      = '0;
    end else begin
      cur_active    = active_q;
      cur_pos       = pos_q;
      cur_odd       = odd_total_q;
      cur_group     = group_total_q;
      cur_odd_msb   = odd_msb_q;
      cur_group_msb = group_msb_q;
      cur_csum      = csum_q;
      cur_even      = even_bits_q;
    end

    rel     = cur_pos - HdrLen;
    odd_len = {4'd0, cur_odd} + ((cur_odd != 7'd0) ? 11'd1 : 11'd0);
    rel_grp = rel - odd_len;
    grp_len = {1'b0, cur_group, 3'b000};
    rel_chk = rel_grp - grp_len;
    expect_sum = ((rx_byte_i & ChkMask) << 1) | cur_even;
    dec = '0;

    active_d      = cur_active;
    pos_d         = cur_pos;
    odd_total_d   = cur_odd;
    group_total_d = cur_group;
    odd_msb_d     = cur_odd_msb;
    group_msb_d   = cur_group_msb;
    csum_d        = cur_csum;
    even_bits_d   = cur_even;

    res_valid = 1'b0;
    res_data  = '0;
    res_final = 1'b0;
    res_err   = 1'b0;
    res_count = '0;

    if (cur_active) begin
      pos_d = cur_pos + 11'd1;
      if (cur_pos < HdrLen) begin
        csum_d = cur_csum ^ rx_byte_i;
        if (cur_pos == OddCountPos) begin
          odd_total_d = rx_byte_i[6:0];
        end else if (cur_pos == GroupCountPos) begin
          group_total_d = rx_byte_i[6:0];
        end
      end else if (rel < odd_len) begin
        if (rel == '0) begin
          odd_msb_d = rx_byte_i;
        end else begin
          dec       = rebuild(cur_odd_msb, rel, rx_byte_i);
          csum_d    = cur_csum ^ dec;
          res_valid = 1'b1;
          res_data  = dec;
        end
      end else if (rel_grp < grp_len) begin
        if (rel_grp[2:0] == 3'd0) begin
          group_msb_d = rx_byte_i;
        end else begin
          dec       = rebuild(cur_group_msb, {8'd0, rel_grp[2:0]}, rx_byte_i);
          csum_d    = cur_csum ^ dec;
          res_valid = 1'b1;
          res_data  = dec;
        end
      end else if (rel_chk == '0) begin
        even_bits_d = rx_byte_i & ChkMask;
      end else begin
        res_valid = 1'b1;
        res_final = 1'b1;
        res_err   = (cur_csum != expect_sum);
        res_count = {cur_group, 3'b000} - {3'd0, cur_group} + {3'd0, cur_odd};
        active_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= 1'b0;
      pos_q         <= '0;
      odd_total_q   <= '0;
      group_total_q <= '0;
      odd_msb_q     <= '0;
      group_msb_q   <= '0;
      csum_q        <= '0;
      even_bits_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        active_q      <= active_d;
        pos_q         <= pos_d;
        odd_total_q   <= odd_total_d;
        group_total_q <= group_total_d;
        odd_msb_q     <= odd_msb_d;
        group_msb_q   <= group_msb_d;
        csum_q        <= csum_d;
        even_bits_q   <= even_bits_d;
        out_valid_q   <= res_valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      data_byte_q <= res_data;
      is_final_q  <= res_final;
      chk_err_q   <= res_err;
      count_q     <= res_count;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign data_byte_o      = data_byte_q;
  assign is_final_o       = is_final_q;
  assign checksum_error_o = chk_err_q;
  assign data_count_o     = count_q;

endmodule

// ----- src/grp7_checker.sv -----
// Port-level checker of the packet decoder and its bind to the top level.
module grp7_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [7:0]                  rx_byte_i,
  input logic                        start_of_packet_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [7:0]                  data_byte_o,
  input logic                        is_final_o,
  input logic                        checksum_error_o,
  input logic [grp7_pkg::CountW-1:0] data_count_o
);
  import grp7_pkg::*;

  // A stalled result request keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_byte_o) &&
      $stable(is_final_o) && $stable(checksum_error_o) && $stable(data_count_o))
    else $error("result changed while stalled");

  // A full output register that is not being read blocks the input.
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input ready while result register is full");

  a_final_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_final_o |-> data_byte_o == 8'd0 && data_count_o <= DataCountMax)
    else $error("bad final result fields");

  a_data_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_final_o |-> !checksum_error_o && data_count_o == '0)
    else $error("data result carries final fields");

endmodule

bind group7_packet_decoder grp7_checker u_grp7_checker (.*);

// ----- dv/group7_decode_checker.sv -----
// Checker that predicts the decoder's results from its byte requests and compares them.
module group7_decode_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [7:0]                  rx_byte_i,
  input  logic                        start_of_packet_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [7:0]                  data_byte_i,
  input  logic                        is_final_i,
  input  logic                        checksum_error_i,
  input  logic [grp7_pkg::CountW-1:0] data_count_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          data_seen_o,
  output int                          ends_seen_o,
  output int                          bad_sums_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import grp7_pkg::*;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic              is_final;
    logic              checksum_error;
    logic [CountW-1:0] data_count;
  } decoded_t;

  decoded_t decoded_q[$];

  // Shadow of the decoder state.
  logic            pkt_active = 1'b0;
  logic [PosW-1:0] next_pos = '0;
  logic [6:0]      odd_count = '0;
  logic [6:0]      group_count = '0;
  logic [7:0]      odd_carrier = '0;
  logic [7:0]      group_carrier = '0;
  logic [7:0]      xor_sum = '0;
  logic [7:0]      even_sum_bits = '0;

  int mismatches = 0;
  int data_seen = 0;
  int ends_seen = 0;
  int bad_sums = 0;

  function automatic void clear_decode();
    pkt_active = 1'b0;
    next_pos = '0;
    odd_count = '0;
    group_count = '0;
    odd_carrier = '0;
    group_carrier = '0;
    xor_sum = '0;
    even_sum_bits = '0;
  endfunction

  // Advances the shadow state by one byte; returns 1 when the byte yields a result.
  function automatic bit decode_next(input logic [7:0] b, input logic sop, output decoded_t res);
    logic [PosW-1:0] cur;
    int rel;
    int odd_span;
    int grp_span;
    int k;
    logic hi;
    logic [7:0] rx_sum;
    res = '0;
    if (sop) begin
      clear_decode();
      pkt_active = 1'b1;
    end
    if (!pkt_active) return 1'b0;
    cur = next_pos;
    next_pos = next_pos + 1'b1;
    if (cur < HdrLen) begin
      xor_sum ^= b;
      if (cur == OddCountPos) odd_count = b[6:0];
      else if (cur == GroupCountPos) group_count = b[6:0];
      return 1'b0;
    end
    rel = int'(cur) - int'(HdrLen);
    // The odd carrier byte is only present when there are odd bytes.
    odd_span = (odd_count != 0) ? int'(odd_count) + 1 : 0;
    if (rel < odd_span) begin
      if (rel == 0) begin
        odd_carrier = b;
        return 1'b0;
      end
      // Odd bytes past the seventh have no carrier bit left.
      hi = 1'b0;
      if (rel <= 7) hi = odd_carrier[7 - rel];
      res.data_byte = {hi, b[6:0]};
      xor_sum ^= res.data_byte;
      return 1'b1;
    end
    rel -= odd_span;
    grp_span = int'(group_count) * 8;
    if (rel < grp_span) begin
      k = rel % 8;
      if (k == 0) begin
        group_carrier = b;
        return 1'b0;
      end
      res.data_byte = {group_carrier[7 - k], b[6:0]};
      xor_sum ^= res.data_byte;
      return 1'b1;
    end
    rel -= grp_span;
    if (rel == 0) begin
      even_sum_bits = b & ChkMask;
      return 1'b0;
    end
    rx_sum = ((b & ChkMask) << 1) | even_sum_bits;
    res.is_final = 1'b1;
    res.checksum_error = (xor_sum != rx_sum);
    res.data_count = CountW'(int'(odd_count) + 7 * int'(group_count));
    pkt_active = 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin : monitor
    decoded_t res;
    decoded_t want;
    if (!rst_ni) begin
      clear_decode();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: data_byte %0h is_final %0b checksum_error %0b data_count %0d",
                 data_byte_i, is_final_i, checksum_error_i, data_count_i);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          if (data_byte_i !== want.data_byte) begin
            $error("data_byte: expected %0h, actual %0h", want.data_byte, data_byte_i);
            mismatches++;
          end
          if (is_final_i !== want.is_final) begin
            $error("is_final: expected %0b, actual %0b", want.is_final, is_final_i);
            mismatches++;
          end
          if (checksum_error_i !== want.checksum_error) begin
            $error("checksum_error: expected %0b, actual %0b", want.checksum_error,
                   checksum_error_i);
            mismatches++;
          end
          if (data_count_i !== want.data_count) begin
            $error("data_count: expected %0d, actual %0d", want.data_count, data_count_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (decode_next(rx_byte_i, start_of_packet_i, res)) begin
          decoded_q.push_back(res);
          if (res.is_final) begin
            ends_seen++;
            if (res.checksum_error) bad_sums++;
          end else begin
            data_seen++;
          end
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o <= decoded_q.size();
    data_seen_o <= data_seen;
    ends_seen_o <= ends_seen;
    bad_sums_seen_o <= bad_sums;
  end

endmodule

// ----- dv/tb.sv -----
// Testbench top that sends packet byte requests to group7_packet_decoder and gives the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import grp7_pkg::*;

  localparam int ItemTarget = 1675;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        rx_byte_i;
  logic              start_of_packet_i;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [7:0]        data_byte_o;
  logic              is_final_o;
  logic              checksum_error_o;
  logic [CountW-1:0] data_count_o;

  int fail_count;
  int pending;
  int data_seen;
  int ends_seen;
  int bad_sums;

  int          packet_bytes = 0;
  int unsigned cycle_cnt = 0;
  logic        quiet;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  group7_packet_decoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .start_of_packet_i(start_of_packet_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .data_byte_o      (data_byte_o),
    .is_final_o       (is_final_o),
    .checksum_error_o (checksum_error_o),
    .data_count_o     (data_count_o)
  );

  group7_decode_checker decode_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .start_of_packet_i(start_of_packet_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .data_byte_i      (data_byte_o),
    .is_final_i       (is_final_o),
    .checksum_error_i (checksum_error_o),
    .data_count_i     (data_count_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .data_seen_o      (data_seen),
    .ends_seen_o      (ends_seen),
    .bad_sums_seen_o  (bad_sums)
  );

  // Both sides run without stalls inside this window.
  assign quiet = (cycle_cnt >= 1500) && (cycle_cnt < 2500);

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    out_ready_i <= quiet || ($urandom_range(99) >= 36);
  end

  function automatic logic [7:0] pick_byte(input int fill);
    return (fill < 0) ? 8'($urandom) : 8'(fill);
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic sop);
    while (!quiet && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    start_of_packet_i <= sop;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Builds a packet the way a sender would encode it. A negative fill gives random bytes;
  // cut of 0 truncates at a random point, a positive cut sends only that many bytes.
  task automatic send_packet(input int odd_n, input int grp_n, input int fill,
                             input bit bad_sum, input int cut);
    logic [7:0] pkt[$];
    logic [7:0] cks;
    logic [7:0] msb;
    logic [7:0] raw;
    logic hi;
    int n;
    pkt = {};
    cks = '0;
    for (int i = 0; i < 7; i++) begin
      raw = pick_byte(fill);
      if (i == OddCountPos) raw[6:0] = 7'(odd_n);
      else if (i == GroupCountPos) raw[6:0] = 7'(grp_n);
      cks ^= raw;
      pkt.push_back(raw);
    end
    if (odd_n > 0) begin
      msb = pick_byte(fill);
      pkt.push_back(msb);
      for (int i = 1; i <= odd_n; i++) begin
        raw = pick_byte(fill);
        hi = 1'b0;
        if (i <= 7) hi = msb[7 - i];
        cks ^= {hi, raw[6:0]};
        pkt.push_back(raw);
      end
    end
    for (int g = 0; g < grp_n; g++) begin
      msb = pick_byte(fill);
      pkt.push_back(msb);
      for (int k = 1; k <= 7; k++) begin
        raw = pick_byte(fill);
        cks ^= {msb[7 - k], raw[6:0]};
        pkt.push_back(raw);
      end
    end
    if (bad_sum) cks ^= 8'($urandom_range(1, 255));
    raw = pick_byte(fill);
    pkt.push_back((cks & ChkMask) | (raw & ~ChkMask));
    raw = pick_byte(fill);
    pkt.push_back(((cks >> 1) & ChkMask) | (raw & ~ChkMask));
    n = pkt.size();
    if (cut == 0) n = $urandom_range(1, pkt.size() - 1);
    else if (cut > 0) n = cut;
    for (int i = 0; i < n; i++) push_byte(pkt[i], i == 0);
    packet_bytes += n;
  endtask

  initial begin : stimulus
    int pkt_idx;
    int odd_n;
    int grp_n;
    int sel;
    int cut;
    bit bad;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    rx_byte_i = '0;
    start_of_packet_i = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Bytes before any start are dropped; then an empty packet of all ones, a truncated
    // packet of zeros, and a restart into one odd byte with a corrupted checksum.
    push_byte(8'hff, 1'b0);
    push_byte(8'h00, 1'b0);
    send_packet(0, 0, 8'hff, 1'b0, -1);
    send_packet(0, 0, 8'h00, 1'b0, 3);
    send_packet(1, 0, 8'hff, 1'b1, -1);

    pkt_idx = 0;
    while (packet_bytes < ItemTarget) begin
      sel = $urandom_range(99);
      odd_n = (sel < 20) ? 0 : (sel < 88) ? $urandom_range(1, 9) : $urandom_range(10, 127);
      sel = $urandom_range(99);
      grp_n = (sel < 30) ? 0 : (sel < 95) ? $urandom_range(1, 3) : $urandom_range(4, 12);
      bad = ($urandom_range(99) < 15);
      cut = ($urandom_range(99) < 10) ? 0 : -1;
      // One full-size packet reaches the largest byte count.
      if (pkt_idx == 4) begin
        odd_n = 127;
        grp_n = 127;
        cut = -1;
      end
      send_packet(odd_n, grp_n, -1, bad, cut);
      sel = $urandom_range(99);
      if (sel < 25) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
      end else if (sel < 30) begin
        push_byte(8'($urandom), 1'($urandom_range(1)));
      end
      pkt_idx++;
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    $display("Sent %0d packet bytes in %0d random and 3 directed packets.",
             packet_bytes, pkt_idx);
    $display("Checked %0d data bytes and %0d packet ends, %0d with a bad checksum.",
             data_seen, ends_seen, bad_sums);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
